@@ design/mrtu_pkg.sv @@
// Shared types, constants and the CRC-16 byte step for the Modbus RTU slave engine.
// Used by mrtu_front, mrtu_back and modbus_rtu_slave_engine; depends on nothing.
`timescale 1ns / 1ps

package mrtu_pkg;

    localparam int SENSOR_REGS_DEF = 8;
    localparam int HOLD_REGS_DEF   = 8;
    localparam int FRAME_BYTES_DEF = 32;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [15:0] READ_QTY_MAX  = 16'd125;
    localparam logic [15:0] WRITE_QTY_MAX = 16'd123;

    localparam logic [7:0] FC_READ_INPUT     = 8'h04;
    localparam logic [7:0] FC_WRITE_SINGLE   = 8'h06;
    localparam logic [7:0] FC_WRITE_MULTI    = 8'h10;
    localparam logic [7:0] EXC_FLAG          = 8'h80;
    localparam logic [7:0] EXC_ILLEGAL_FUNC  = 8'h01;
    localparam logic [7:0] EXC_ILLEGAL_ADDR  = 8'h02;
    localparam logic [7:0] EXC_ILLEGAL_VALUE = 8'h03;

    localparam logic [7:0] SLAVE_ADDR_RESET  = 8'h01;
    localparam logic [2:0] ADDR_SLAVE_ADDRESS = 3'd0;

    typedef enum logic [0:0] {
        ITEM_BYTE,
        ITEM_SENSOR
    } item_kind_t;

    typedef struct packed {
        item_kind_t         kind;
        logic [7:0]         data;
        logic               last;
        logic [2:0]         sidx;
        logic signed [15:0] svalue;
    } q_item_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_CHECK,
        B_WR_RD,
        B_WR_HI,
        B_WR_LO,
        B_SEND,
        B_ECHO_RD,
        B_ECHO_PUT
    } back_state_t;

    typedef enum logic [1:0] {
        RSP_EXC,
        RSP_READ,
        RSP_WRITE
    } resp_kind_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ design/modbus_rtu_slave_engine.sv @@
// Modbus RTU slave engine: top level with APB register port, front queue and back end.
// Depends on mrtu_pkg, mrtu_front and mrtu_back.
`timescale 1ns / 1ps

// Frame bytes and sensor updates enter through a four-request queue; a byte or
// an update is taken whenever the queue is not full. On the byte marked as the
// end of a frame the back end checks the frame, applies register writes (read,
// high and low states per register of a multiple write) and sends the response
// one byte per cycle from an output register while the receiver does not stall;
// an echoed write-single request alternates a read and an output state per byte,
// as each byte passes through the registered frame buffer read. While a response
// is going out, and until its last byte has been taken, no further request is
// taken from the queue, so the input stalls once the queue is full.

module modbus_rtu_slave_engine #(
    parameter int SENSOR_REGS = mrtu_pkg::SENSOR_REGS_DEF,
    parameter int HOLD_REGS   = mrtu_pkg::HOLD_REGS_DEF,
    parameter int FRAME_BYTES = mrtu_pkg::FRAME_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               cmd,
    input  logic [7:0]         rx_byte,
    input  logic               frame_end,
    input  logic [2:0]         sensor_index,
    input  logic signed [15:0] sensor_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         tx_byte,
    output logic               tx_last,
    output logic [15:0]        fan_a_duty,
    output logic [15:0]        fan_b_duty
);

    logic [7:0] slave_addr_reg;
    logic       q_valid;
    logic       q_pop;
    mrtu_pkg::q_item_t q_item;

    assign pready = 1'b1;
    assign prdata = (paddr == mrtu_pkg::ADDR_SLAVE_ADDRESS) ? {24'h0, slave_addr_reg} : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slave_addr_reg <= mrtu_pkg::SLAVE_ADDR_RESET;
        else if (psel && penable && pwrite && paddr == mrtu_pkg::ADDR_SLAVE_ADDRESS)
            slave_addr_reg <= pwdata[7:0];
    end

    mrtu_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .rx_byte      (rx_byte),
        .frame_end    (frame_end),
        .sensor_index (sensor_index),
        .sensor_value (sensor_value),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    mrtu_back #(
        .SENSOR_REGS (SENSOR_REGS),
        .HOLD_REGS   (HOLD_REGS),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .slave_address (slave_addr_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .tx_byte       (tx_byte),
        .tx_last       (tx_last),
        .fan_a_duty    (fan_a_duty),
        .fan_b_duty    (fan_b_duty)
    );

endmodule

@@ design/mrtu_front.sv @@
// Front end: accepts input items, tags them as frame bytes or sensor updates
// and queues them for the back end. Depends on mrtu_pkg.
`timescale 1ns / 1ps

module mrtu_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 cmd,
    input  logic [7:0]           rx_byte,
    input  logic                 frame_end,
    input  logic [2:0]           sensor_index,
    input  logic signed [15:0]   sensor_value,
    output logic                 q_valid,
    output mrtu_pkg::q_item_t    q_item,
    input  logic                 q_pop
);

    localparam int PW = $clog2(mrtu_pkg::QUEUE_DEPTH);

    mrtu_pkg::q_item_t entry_reg [mrtu_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;
    logic          push;
    logic          pop;
    mrtu_pkg::q_item_t new_item;

    assign in_stall = (count_reg == (PW+1)'(mrtu_pkg::QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        new_item.kind   = cmd ? mrtu_pkg::ITEM_SENSOR : mrtu_pkg::ITEM_BYTE;
        new_item.data   = rx_byte;
        new_item.last   = frame_end;
        new_item.sidx   = sensor_index;
        new_item.svalue = sensor_value;
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

@@ design/mrtu_back.sv @@
// Back end: frame buffer, running CRC, request checks, register files and
// the response byte sequencer with its output register. Depends on mrtu_pkg.
`timescale 1ns / 1ps

module mrtu_back #(
    parameter int SENSOR_REGS = mrtu_pkg::SENSOR_REGS_DEF,
    parameter int HOLD_REGS   = mrtu_pkg::HOLD_REGS_DEF,
    parameter int FRAME_BYTES = mrtu_pkg::FRAME_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        slave_address,
    input  logic              q_valid,
    input  mrtu_pkg::q_item_t q_item,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        tx_byte,
    output logic              tx_last,
    output logic [15:0]       fan_a_duty,
    output logic [15:0]       fan_b_duty
);

    localparam int IN_REGS = SENSOR_REGS + HOLD_REGS;
    localparam int CW      = $clog2(FRAME_BYTES + 1);
    localparam int AW      = $clog2(FRAME_BYTES);
    localparam int SIDX    = (SENSOR_REGS > 1) ? $clog2(SENSOR_REGS) : 1;
    localparam int HIDX    = $clog2(HOLD_REGS);
    localparam int RIDX    = $clog2(IN_REGS);

    mrtu_pkg::back_state_t state_reg, state_next;

    logic [7:0]  mem [FRAME_BYTES];
    logic [7:0]  mem_q_reg;
    logic [AW-1:0] rd_addr;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ovf_reg, ovf_next;
    logic [7:0]    hdr_reg [7];
    logic [7:0]    b1_reg, b2_reg;
    logic [15:0]   crc_cur_reg, crc_d1_reg, crc_d2_reg;
    logic [15:0]   crc_base;

    logic [15:0] sensor_reg [SENSOR_REGS];
    logic [15:0] hold_reg [HOLD_REGS];

    mrtu_pkg::resp_kind_t kind_reg, kind_next;
    logic [7:0]      fc_out_reg, fc_out_next;
    logic [7:0]      third_reg, third_next;
    logic [6:0]      body_len_reg, body_len_next;
    logic [6:0]      k_reg, k_next;
    logic [CW-1:0]   echo_len_reg, echo_len_next;
    logic [RIDX-1:0] rd_idx_reg, rd_idx_next;
    logic            lo_reg, lo_next;
    logic [HIDX-1:0] wr_idx_reg, wr_idx_next;
    logic [4:0]      rem_reg, rem_next;
    logic [6:0]      wptr_reg, wptr_next;
    logic [7:0]      hi_reg, hi_next;
    logic [15:0]     tcrc_reg, tcrc_next;

    logic            out_valid_reg, out_valid_next;
    logic [7:0]      tx_byte_reg, tx_byte_next;
    logic            tx_last_reg, tx_last_next;

    // decode of a finished frame
    logic        is_byte, is_sensor, store_ok;
    logic        out_free, out_load;
    logic [7:0]  len8;
    logic [15:0] start16, qty16;
    logic [16:0] sum17;
    logic        frame_ok;
    logic        dec_echo, dec_multi;
    logic [7:0]  fc;
    logic [15:0] word_val;
    logic [7:0]  body_byte;
    logic        send_body;

    assign is_byte   = q_pop && (q_item.kind == mrtu_pkg::ITEM_BYTE);
    assign is_sensor = q_pop && (q_item.kind == mrtu_pkg::ITEM_SENSOR);
    assign store_ok  = (cnt_reg < CW'(FRAME_BYTES));
    assign crc_base  = (cnt_reg == '0) ? mrtu_pkg::CRC_INIT : crc_cur_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign len8    = 8'(cnt_reg);
    assign fc      = hdr_reg[1];
    assign start16 = {hdr_reg[2], hdr_reg[3]};
    assign qty16   = {hdr_reg[4], hdr_reg[5]};
    assign sum17   = {1'b0, start16} + {1'b0, qty16};
    assign frame_ok = !ovf_reg && (len8 >= 8'd4) && (hdr_reg[0] == slave_address)
                      && (crc_d2_reg == {b1_reg, b2_reg});

    assign word_val = (rd_idx_reg < RIDX'(SENSOR_REGS))
                      ? sensor_reg[rd_idx_reg[SIDX-1:0]]
                      : hold_reg[HIDX'(rd_idx_reg - RIDX'(SENSOR_REGS))];
    assign send_body = (k_reg < body_len_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mrtu_pkg::B_IDLE:
            begin
                if (is_byte && q_item.last)
                    state_next = mrtu_pkg::B_CHECK;
            end
            mrtu_pkg::B_CHECK:
            begin
                if (!frame_ok)
                    state_next = mrtu_pkg::B_IDLE;
                else if (dec_echo)
                    state_next = mrtu_pkg::B_ECHO_RD;
                else if (dec_multi)
                    state_next = mrtu_pkg::B_WR_RD;
                else
                    state_next = mrtu_pkg::B_SEND;
            end
            mrtu_pkg::B_WR_RD:  state_next = mrtu_pkg::B_WR_HI;
            mrtu_pkg::B_WR_HI:  state_next = mrtu_pkg::B_WR_LO;
            mrtu_pkg::B_WR_LO:
            begin
                state_next = (rem_reg == 5'd1) ? mrtu_pkg::B_SEND : mrtu_pkg::B_WR_RD;
            end
            mrtu_pkg::B_SEND:
            begin
                if (out_free && !send_body && (k_reg != body_len_reg))
                    state_next = mrtu_pkg::B_IDLE;
            end
            mrtu_pkg::B_ECHO_RD: state_next = mrtu_pkg::B_ECHO_PUT;
            mrtu_pkg::B_ECHO_PUT:
            begin
                if (out_free)
                    state_next = (7'(echo_len_reg) == k_reg + 7'd1)
                                 ? mrtu_pkg::B_IDLE : mrtu_pkg::B_ECHO_RD;
            end
            default: state_next = mrtu_pkg::B_IDLE;
        endcase
    end

    // outputs of the state machine; the fan values go out with every byte,
    // so nothing is taken from the queue until the last byte has left
    always_comb
    begin
        q_pop    = (state_reg == mrtu_pkg::B_IDLE) && q_valid && !out_valid_reg;
        out_load = out_free && ((state_reg == mrtu_pkg::B_SEND)
                                || (state_reg == mrtu_pkg::B_ECHO_PUT));
        case (state_reg)
            mrtu_pkg::B_WR_RD: rd_addr = AW'(wptr_reg);
            mrtu_pkg::B_WR_HI: rd_addr = AW'(wptr_reg + 7'd1);
            default:           rd_addr = AW'(k_reg);
        endcase
    end

    // request checks, in the order the protocol defines
    always_comb
    begin
        dec_echo    = 1'b0;
        dec_multi   = 1'b0;
        kind_next   = kind_reg;
        fc_out_next = fc_out_reg;
        third_next  = third_reg;
        body_len_next = body_len_reg;
        if (state_reg == mrtu_pkg::B_CHECK)
        begin
            kind_next     = mrtu_pkg::RSP_EXC;
            fc_out_next   = fc | mrtu_pkg::EXC_FLAG;
            body_len_next = 7'd3;
            third_next    = mrtu_pkg::EXC_ILLEGAL_FUNC;
            case (fc)
                mrtu_pkg::FC_READ_INPUT:
                begin
                    if (len8 < 8'd8 || qty16 == '0 || qty16 > mrtu_pkg::READ_QTY_MAX)
                        third_next = mrtu_pkg::EXC_ILLEGAL_VALUE;
                    else if (sum17 > 17'(IN_REGS))
                        third_next = mrtu_pkg::EXC_ILLEGAL_ADDR;
                    else
                    begin
                        kind_next     = mrtu_pkg::RSP_READ;
                        fc_out_next   = fc;
                        third_next    = {qty16[6:0], 1'b0};
                        body_len_next = 7'd3 + {qty16[5:0], 1'b0};
                    end
                end
                mrtu_pkg::FC_WRITE_SINGLE:
                begin
                    if (len8 < 8'd8)
                        third_next = mrtu_pkg::EXC_ILLEGAL_VALUE;
                    else if (start16 >= 16'(HOLD_REGS))
                        third_next = mrtu_pkg::EXC_ILLEGAL_ADDR;
                    else
                        dec_echo = 1'b1;
                end
                mrtu_pkg::FC_WRITE_MULTI:
                begin
                    if (len8 < 8'd9 || qty16 == '0 || qty16 > mrtu_pkg::WRITE_QTY_MAX)
                        third_next = mrtu_pkg::EXC_ILLEGAL_VALUE;
                    else if ({1'b0, hdr_reg[6]} != {qty16[7:0], 1'b0})
                        third_next = mrtu_pkg::EXC_ILLEGAL_VALUE;
                    else if (sum17 > 17'(HOLD_REGS))
                        third_next = mrtu_pkg::EXC_ILLEGAL_ADDR;
                    else if ({1'b0, len8} < 9'd9 + {1'b0, hdr_reg[6]})
                        third_next = mrtu_pkg::EXC_ILLEGAL_VALUE;
                    else
                    begin
                        dec_multi     = 1'b1;
                        kind_next     = mrtu_pkg::RSP_WRITE;
                        fc_out_next   = fc;
                        third_next    = hdr_reg[2];
                        body_len_next = 7'd6;
                    end
                end
                default: third_next = mrtu_pkg::EXC_ILLEGAL_FUNC;
            endcase
        end
    end

    // response byte for the current position
    always_comb
    begin
        case (k_reg)
            7'd0: body_byte = slave_address;
            7'd1: body_byte = fc_out_reg;
            7'd2: body_byte = third_reg;
            7'd3: body_byte = (kind_reg == mrtu_pkg::RSP_READ)
                              ? (lo_reg ? word_val[7:0] : word_val[15:8]) : hdr_reg[3];
            7'd4: body_byte = (kind_reg == mrtu_pkg::RSP_READ)
                              ? (lo_reg ? word_val[7:0] : word_val[15:8]) : hdr_reg[4];
            7'd5: body_byte = (kind_reg == mrtu_pkg::RSP_READ)
                              ? (lo_reg ? word_val[7:0] : word_val[15:8]) : hdr_reg[5];
            default: body_byte = lo_reg ? word_val[7:0] : word_val[15:8];
        endcase
    end

    // datapath
    always_comb
    begin
        cnt_next      = cnt_reg;
        ovf_next      = ovf_reg;
        k_next        = k_reg;
        echo_len_next = echo_len_reg;
        rd_idx_next   = rd_idx_reg;
        lo_next       = lo_reg;
        wr_idx_next   = wr_idx_reg;
        rem_next      = rem_reg;
        wptr_next     = wptr_reg;
        hi_next       = hi_reg;
        tcrc_next     = tcrc_reg;
        tx_byte_next  = tx_byte_reg;
        tx_last_next  = tx_last_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (is_byte)
        begin
            if (store_ok)
                cnt_next = cnt_reg + 1'b1;
            else
                ovf_next = 1'b1;
        end

        case (state_reg)
            mrtu_pkg::B_CHECK:
            begin
                cnt_next      = '0;
                ovf_next      = 1'b0;
                k_next        = '0;
                echo_len_next = cnt_reg;
                tcrc_next     = mrtu_pkg::CRC_INIT;
                rd_idx_next   = RIDX'(start16);
                lo_next       = 1'b0;
                wr_idx_next   = HIDX'(start16);
                rem_next      = qty16[4:0];
                wptr_next     = 7'd7;
            end
            mrtu_pkg::B_WR_HI: hi_next = mem_q_reg;
            mrtu_pkg::B_WR_LO:
            begin
                wr_idx_next = wr_idx_reg + 1'b1;
                rem_next    = rem_reg - 5'd1;
                wptr_next   = wptr_reg + 7'd2;
            end
            mrtu_pkg::B_SEND:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    k_next = k_reg + 7'd1;
                    if (send_body)
                    begin
                        tx_byte_next = body_byte;
                        tx_last_next = 1'b0;
                        tcrc_next    = mrtu_pkg::crc_byte(tcrc_reg, body_byte);
                        if (kind_reg == mrtu_pkg::RSP_READ && k_reg >= 7'd3)
                        begin
                            lo_next = !lo_reg;
                            if (lo_reg)
                                rd_idx_next = rd_idx_reg + 1'b1;
                        end
                    end
                    else if (k_reg == body_len_reg)
                    begin
                        tx_byte_next = tcrc_reg[7:0];
                        tx_last_next = 1'b0;
                    end
                    else
                    begin
                        tx_byte_next = tcrc_reg[15:8];
                        tx_last_next = 1'b1;
                    end
                end
            end
            mrtu_pkg::B_ECHO_PUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    tx_byte_next   = mem_q_reg;
                    tx_last_next   = (7'(echo_len_reg) == k_reg + 7'd1);
                    k_next         = k_reg + 7'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mrtu_pkg::B_IDLE;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SENSOR_REGS; i++)
            begin
                sensor_reg[i] <= '0;
            end
            for (int i = 0; i < HOLD_REGS; i++)
            begin
                hold_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            if (is_sensor && ({2'b00, q_item.sidx} < 5'(SENSOR_REGS)))
                sensor_reg[SIDX'({2'b00, q_item.sidx})] <= q_item.svalue;
            if (state_reg == mrtu_pkg::B_CHECK && frame_ok && dec_echo)
                hold_reg[HIDX'(start16)] <= qty16;
            if (state_reg == mrtu_pkg::B_WR_LO)
                hold_reg[wr_idx_reg] <= {hi_reg, mem_q_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_byte && store_ok)
        begin
            mem[cnt_reg[AW-1:0]] <= q_item.data;
            if (cnt_reg < CW'(7))
                hdr_reg[cnt_reg[2:0]] <= q_item.data;
            b2_reg      <= b1_reg;
            b1_reg      <= q_item.data;
            crc_d2_reg  <= crc_d1_reg;
            crc_d1_reg  <= crc_base;
            crc_cur_reg <= mrtu_pkg::crc_byte(crc_base, q_item.data);
        end
        mem_q_reg    <= mem[rd_addr];
        kind_reg     <= kind_next;
        fc_out_reg   <= fc_out_next;
        third_reg    <= third_next;
        body_len_reg <= body_len_next;
        k_reg        <= k_next;
        echo_len_reg <= echo_len_next;
        rd_idx_reg   <= rd_idx_next;
        lo_reg       <= lo_next;
        wr_idx_reg   <= wr_idx_next;
        rem_reg      <= rem_next;
        wptr_reg     <= wptr_next;
        hi_reg       <= hi_next;
        tcrc_reg     <= tcrc_next;
        tx_byte_reg  <= tx_byte_next;
        tx_last_reg  <= tx_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign tx_byte    = tx_byte_reg;
    assign tx_last    = tx_last_reg;
    assign fan_a_duty = hold_reg[2];
    assign fan_b_duty = hold_reg[3];

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(FRAME_BYTES))
        else $error("frame count beyond buffer");

    a_check_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mrtu_pkg::B_CHECK) |=> (cnt_reg == '0) && !ovf_reg)
        else $error("frame state not cleared after end of frame");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && tx_last_next) |=> (state_reg == mrtu_pkg::B_IDLE))
        else $error("sequencer kept running after last byte");

endmodule

@@ test/tb_top.sv @@
// Testbench for modbus_rtu_slave_engine: random and directed Modbus frames and sensor updates,
// responses checked byte by byte against a behavioral model. Depends on mrtu_pkg and the RTL.
`timescale 1ns / 1ps

class rtu_scoreboard;
    logic [7:0]  station;
    logic [7:0]  fbuf [32];
    int          fcnt;
    bit          fover;
    logic [15:0] hold [8];
    logic [15:0] sens [8];
    logic [7:0]  rsp_byte [$];
    bit          rsp_last [$];
    logic [15:0] rsp_fa [$];
    logic [15:0] rsp_fb [$];
    int          errors;

    function new();
        station = mrtu_pkg::SLAVE_ADDR_RESET;
        fcnt = 0;
        fover = 0;
        errors = 0;
        foreach (hold[i]) hold[i] = '0;
        foreach (sens[i]) sens[i] = '0;
    endfunction

    function logic [15:0] crc16(logic [7:0] b [$]);
        logic [15:0] c;
        c = 16'hFFFF;
        foreach (b[i])
        begin
            c = c ^ {8'h00, b[i]};
            for (int k = 0; k < 8; k++)
                c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        return c;
    endfunction

    function void exc(ref logic [7:0] r [$], input logic [7:0] fc, input logic [7:0] code);
        r = {station, fc | mrtu_pkg::EXC_FLAG, code};
    endfunction

    function void serve(ref logic [7:0] r [$]);
        logic [7:0]  f [$];
        logic [7:0]  fc;
        logic [15:0] c;
        int          start, qty, n;
        bit          with_crc;
        for (int i = 0; i < fcnt; i++) f.push_back(fbuf[i]);
        r = {};
        with_crc = 1;
        if (fcnt < 4 || f[0] != station) return;
        c = crc16(f[0:fcnt-3]);
        if (c != {f[fcnt-1], f[fcnt-2]}) return;
        fc = f[1];
        if (fc == mrtu_pkg::FC_READ_INPUT)
        begin
            if (fcnt < 8) exc(r, fc, mrtu_pkg::EXC_ILLEGAL_VALUE);
            else
            begin
                start = {f[2], f[3]};
                qty = {f[4], f[5]};
                if (qty == 0 || qty > 125) exc(r, fc, mrtu_pkg::EXC_ILLEGAL_VALUE);
                else if (start + qty > 16) exc(r, fc, mrtu_pkg::EXC_ILLEGAL_ADDR);
                else
                begin
                    r = {station, fc, 8'(qty * 2)};
                    for (int i = 0; i < qty; i++)
                    begin
                        c = (start + i < 8) ? sens[start + i] : hold[start + i - 8];
                        r.push_back(c[15:8]);
                        r.push_back(c[7:0]);
                    end
                end
            end
        end
        else if (fc == mrtu_pkg::FC_WRITE_SINGLE)
        begin
            if (fcnt < 8) exc(r, fc, mrtu_pkg::EXC_ILLEGAL_VALUE);
            else if ({f[2], f[3]} >= 8) exc(r, fc, mrtu_pkg::EXC_ILLEGAL_ADDR);
            else
            begin
                hold[f[3][2:0]] = {f[4], f[5]};
                r = f;
                with_crc = 0;
            end
        end
        else if (fc == mrtu_pkg::FC_WRITE_MULTI)
        begin
            if (fcnt < 9) exc(r, fc, mrtu_pkg::EXC_ILLEGAL_VALUE);
            else
            begin
                start = {f[2], f[3]};
                qty = {f[4], f[5]};
                n = f[6];
                if (qty == 0 || qty > 123 || n != qty * 2)
                    exc(r, fc, mrtu_pkg::EXC_ILLEGAL_VALUE);
                else if (start + qty > 8) exc(r, fc, mrtu_pkg::EXC_ILLEGAL_ADDR);
                else if (fcnt < 9 + n) exc(r, fc, mrtu_pkg::EXC_ILLEGAL_VALUE);
                else
                begin
                    for (int i = 0; i < qty; i++)
                        hold[start + i] = {f[7 + 2*i], f[8 + 2*i]};
                    r = {station, fc, f[2], f[3], f[4], f[5]};
                end
            end
        end
        else exc(r, fc, mrtu_pkg::EXC_ILLEGAL_FUNC);
        if (with_crc && r.size() > 0)
        begin
            c = crc16(r);
            r.push_back(c[7:0]);
            r.push_back(c[15:8]);
        end
    endfunction

    function void note_request(bit cmd, logic [7:0] b, bit fend, logic [2:0] si, logic [15:0] sv);
        logic [7:0] r [$];
        if (cmd)
        begin
            sens[si] = sv;
            return;
        end
        if (fcnt < 32) fbuf[fcnt++] = b;
        else fover = 1;
        if (!fend) return;
        if (!fover) serve(r);
        fcnt = 0;
        fover = 0;
        foreach (r[k])
        begin
            rsp_byte.push_back(r[k]);
            rsp_last.push_back(k == r.size() - 1);
            rsp_fa.push_back(hold[2]);
            rsp_fb.push_back(hold[3]);
        end
    endfunction

    function void check_result(logic [7:0] b, bit last, logic [15:0] fa, logic [15:0] fb);
        logic [7:0]  eb;
        bit          el;
        logic [15:0] ea, ebb;
        if (rsp_byte.size() == 0)
        begin
            $display("%0t: unexpected response byte %h", $time, b);
            errors++;
            return;
        end
        eb = rsp_byte.pop_front();
        el = rsp_last.pop_front();
        ea = rsp_fa.pop_front();
        ebb = rsp_fb.pop_front();
        if (eb !== b) begin $display("%0t: tx_byte exp %h got %h", $time, eb, b); errors++; end
        if (el !== last) begin $display("%0t: tx_last exp %b got %b", $time, el, last); errors++; end
        if (ea !== fa) begin $display("%0t: fan_a exp %h got %h", $time, ea, fa); errors++; end
        if (ebb !== fb) begin $display("%0t: fan_b exp %h got %h", $time, ebb, fb); errors++; end
    endfunction
endclass

module tb_top;
    logic               clk = 0;
    logic               rst_n = 0;
    logic               psel = 0, penable = 0, pwrite = 0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 0;
    logic               in_stall;
    logic               cmd = 0;
    logic [7:0]         rx_byte = '0;
    logic               frame_end = 0;
    logic [2:0]         sensor_index = '0;
    logic signed [15:0] sensor_value = '0;
    logic               out_valid;
    logic               out_stall = 0;
    logic [7:0]         tx_byte;
    logic               tx_last;
    logic [15:0]        fan_a_duty, fan_b_duty;

    rtu_scoreboard sb = new();
    int  hold_off = 0;
    bit  sent_all = 0;
    logic [7:0] frm [$];

    modbus_rtu_slave_engine uut (.*);

    always #10 clk = ~clk;

    // receiver: random stall, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(tx_byte, tx_last, fan_a_duty, fan_b_duty);
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_stall <= 1;
        end
        else if (sent_all) out_stall <= 0;
        else out_stall <= ($urandom_range(0, 9) < 3);
    end

    function automatic int gap_len();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 40);
    endfunction

    task automatic send_request(bit c, logic [7:0] b, bit fend, logic [2:0] si, logic [15:0] sv);
        int g;
        g = gap_len();
        if ($urandom_range(0, 3) == 0) g = 0;
        repeat (g)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        cmd <= c;
        rx_byte <= b;
        frame_end <= fend;
        sensor_index <= si;
        sensor_value <= sv;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_request(c, b, fend, si, sv);
    endtask

    task automatic send_frame(logic [7:0] f [$], bit add_crc);
        logic [15:0] c;
        if (add_crc)
        begin
            c = sb.crc16(f);
            f.push_back(c[7:0]);
            f.push_back(c[15:8]);
        end
        foreach (f[i]) send_request(0, f[i], i == f.size() - 1, $urandom, $urandom);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (sb.rsp_byte.size() > 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_station(logic [7:0] a);
        psel <= 1;
        pwrite <= 1;
        paddr <= mrtu_pkg::ADDR_SLAVE_ADDRESS;
        pwdata <= {24'h0, a};
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        sb.station = a;
    endtask

    task automatic random_frame();
        logic [7:0] f [$];
        logic [7:0] fc;
        int q, s, k;
        k = $urandom_range(0, 9);
        fc = (k < 3) ? mrtu_pkg::FC_READ_INPUT : (k < 5) ? mrtu_pkg::FC_WRITE_SINGLE :
             (k < 8) ? mrtu_pkg::FC_WRITE_MULTI : 8'($urandom);
        f = {($urandom_range(0, 9) == 0) ? 8'($urandom) : sb.station, fc};
        if (fc == mrtu_pkg::FC_WRITE_MULTI)
        begin
            q = $urandom_range(1, 5);
            s = $urandom_range(0, 8 - q);
            if ($urandom_range(0, 7) == 0) q = $urandom_range(0, 130);
            f = {f, 8'(s >> 8), 8'(s), 8'(q >> 8), 8'(q), 8'(2 * q)};
            if ($urandom_range(0, 9) == 0) f[6] = $urandom;
            for (int i = 0; i < 2 * q && f.size() < 28; i++) f.push_back($urandom);
        end
        else
        begin
            q = $urandom_range(1, 16);
            s = $urandom_range(0, (fc == mrtu_pkg::FC_WRITE_SINGLE) ? 7 : 16 - q);
            if ($urandom_range(0, 7) == 0) s = $urandom_range(0, 65535);
            if ($urandom_range(0, 7) == 0) q = $urandom_range(0, 65535);
            f = {f, 8'(s >> 8), 8'(s), 8'(q >> 8), 8'(q)};
            if ($urandom_range(0, 9) == 0) f.push_back($urandom);
        end
        if ($urandom_range(0, 9) == 0) f = f[0:$urandom_range(0, f.size() - 1)];
        if ($urandom_range(0, 15) == 0)
        begin
            f.push_back($urandom);
            send_frame(f, 0);
        end
        else send_frame(f, 1);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: sensor extremes, ignored-free index range, each served function code
        send_request(1, 0, 0, 0, 16'h8000);
        send_request(1, 0, 0, 7, 16'h7FFF);
        send_request(1, 8'hFF, 1, 3, 16'hFFFF);
        send_frame('{8'h01, 8'h06, 8'h00, 8'h02, 8'hA5, 8'h5A}, 1);
        send_frame('{8'h01, 8'h06, 8'h00, 8'h08, 8'h00, 8'h01}, 1);
        send_frame('{8'h01, 8'h06, 8'h00, 8'h03}, 1);
        send_frame('{8'h01, 8'h04, 8'h00, 8'h00, 8'h00, 8'h10}, 1);
        send_frame('{8'h01, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00}, 1);
        send_frame('{8'h01, 8'h04, 8'h00, 8'h00, 8'h00, 8'h7E}, 1);
        send_frame('{8'h01, 8'h04, 8'h00, 8'h0F, 8'h00, 8'h02}, 1);
        send_frame('{8'h01, 8'h10, 8'h00, 8'h02, 8'h00, 8'h02, 8'h04,
                     8'hFF, 8'hFF, 8'h12, 8'h34}, 1);
        send_frame('{8'h01, 8'h10, 8'h00, 8'h07, 8'h00, 8'h02, 8'h04,
                     8'h00, 8'h00, 8'h00, 8'h00}, 1);
        send_frame('{8'h01, 8'h10, 8'h00, 8'h00, 8'h00, 8'h02, 8'h04, 8'h00}, 1);
        send_frame('{8'h01, 8'h10, 8'h00, 8'h00, 8'h00, 8'h02, 8'h03, 8'h00}, 1);
        send_frame('{8'h01, 8'h2B, 8'h00}, 1);
        send_frame('{8'h01, 8'h04}, 0);
        send_frame('{8'h01, 8'h04, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00}, 0);
        frm = {};
        for (int i = 0; i < 34; i++) frm.push_back($urandom);
        frm[0] = 8'h01;
        send_frame(frm, 1);
        drain();
        write_station(8'd0);
        send_frame('{8'h00, 8'h04, 8'h00, 8'h08, 8'h00, 8'h08}, 1);
        drain();
        write_station(8'd247);
        send_frame('{8'hF7, 8'h04, 8'h00, 8'h00, 8'h00, 8'h10}, 1);
        drain();
        write_station(8'd1);
        // long hold-off so the queue fills and stalls the sender
        hold_off = 300;
        for (int i = 0; i < 4; i++)
            send_frame('{8'h01, 8'h04, 8'h00, 8'h00, 8'h00, 8'h10}, 1);
        for (int p = 0; p < 3; p++)
        begin
            for (int i = 0; i < 5; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_request(1, $urandom, $urandom, $urandom, $urandom);
                else if ($urandom_range(0, 9) == 0)
                    send_request(0, $urandom, $urandom_range(0, 3) == 0, $urandom, $urandom);
                else random_frame();
            end
            drain();
            write_station(p == 2 ? 8'd1 : 8'($urandom_range(1, 247)));
        end
        sent_all = 1;
        drain();
        if (sb.errors == 0 && sb.rsp_byte.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule

@@ files.f @@
design/mrtu_pkg.sv
design/mrtu_front.sv
design/mrtu_back.sv
design/modbus_rtu_slave_engine.sv
test/tb_top.sv
